### design/iphp_pkg.sv
// iphp_pkg: shared constants and types for the ip/tcp/udp header parser
// no dependencies; used by every module of the parser
`timescale 1ns / 1ps
`default_nettype none

package iphp_pkg;

    // byte counter width and saturation value
    localparam int unsigned CNT_W   = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // ip versions as seen in the high nibble of byte 0
    localparam logic [3:0] VER_V4 = 4'd4;
    localparam logic [3:0] VER_V6 = 4'd6;

    // l4 protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // fixed header sizes in bytes
    localparam int unsigned V4_MIN_HDR  = 20;
    localparam int unsigned V6_HDR      = 40;
    localparam int unsigned TCP_MIN_HDR = 20;
    localparam int unsigned UDP_HDR     = 8;

    // default depth of the queue between capture and check
    localparam int unsigned JOBQ_DEPTH = 2;

    // one finished packet, as captured by the front end
    typedef struct packed {
        logic [7:0]       first_byte;
        logic [CNT_W-1:0] len;
        logic [15:0]      ip_len;
        logic [7:0]       proto;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [3:0]       tcp_off;
        logic [15:0]      udp_len;
    } t_job;

endpackage

`default_nettype wire

### design/ip_tcp_udp_header_parser.sv
// ip_tcp_udp_header_parser: top level of the ipv4/ipv6 tcp/udp header parser
// depends on iphp_pkg, iphp_front, iphp_jobq and iphp_back
`timescale 1ns / 1ps
`default_nettype none

// Streams a packet in one byte per cycle, starting at the first byte of the
// ip header, with end of packet marking its last byte; each packet yields one
// result request on the output queue. The byte side takes a new byte every
// cycle and never stalls while results are drained as fast as packets end:
// the front end only counts bytes and captures header fields, the finished
// captures go into a JOBQ_DEPTH entry job queue, and a two-stage checker
// (ip header, then tcp/udp) writes the result register. A finished packet
// goes through job queue, checker stage and result register in turn. full rises
// only once the job queue, the checker stage and the result register are all
// held by pending results. A result with status set (parse error) has every
// other field at zero. IPv6 extension headers are not walked: the next header
// byte is taken as the l4 protocol. The byte counter saturates at 2^17-1.
module ip_tcp_udp_header_parser #(
    parameter int unsigned JOBQ_DEPTH = iphp_pkg::JOBQ_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // byte side
    input  wire         push,
    output logic        full,
    input  wire [7:0]   i_data_byte,
    input  wire         i_end_of_packet,
    // result side
    output logic        empty,
    input  wire         pop,
    output logic        o_status,
    output logic [2:0]  o_ip_version,
    output logic [7:0]  o_protocol,
    output logic [5:0]  o_ip_header_length,
    output logic [5:0]  o_l4_header_length,
    output logic [6:0]  o_header_length,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port
);

    // captured packet from the front end into the queue
    logic           job_wr;
    iphp_pkg::t_job job_in;
    // queue head towards the checker
    logic           q_full;
    logic           q_valid;
    logic           q_rd;
    iphp_pkg::t_job q_job;

    assign full = q_full;

    // byte counting and field capture
    iphp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_q_full        (q_full),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_job_wr        (job_wr),
        .o_job           (job_in)
    );

    // decouples capture from checking so each side stalls on its own
    iphp_jobq #(
        .DEPTH (JOBQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_job   (job_in),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // header checks and the result register
    iphp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job_valid        (q_valid),
        .i_job              (q_job),
        .o_job_rd           (q_rd),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_status           (o_status),
        .o_ip_version       (o_ip_version),
        .o_protocol         (o_protocol),
        .o_ip_header_length (o_ip_header_length),
        .o_l4_header_length (o_l4_header_length),
        .o_header_length    (o_header_length),
        .o_payload_length   (o_payload_length),
        .o_src_port         (o_src_port),
        .o_dst_port         (o_dst_port)
    );

`ifndef SYNTH
    // nothing is waiting on the result side right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");
`endif

endmodule

`default_nettype wire

### design/iphp_front.sv
// iphp_front: byte counter and header field capture, one packet byte per cycle
// while the job queue has room; depends on iphp_pkg; hands one t_job per packet
`timescale 1ns / 1ps
`default_nettype none

module iphp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire                 i_q_full,
    input  wire [7:0]           i_data_byte,
    input  wire                 i_end_of_packet,
    output logic                o_job_wr,
    output iphp_pkg::t_job      o_job
);

    logic [iphp_pkg::CNT_W-1:0] r_count, n_count;
    logic [7:0]                 r_first, n_first;
    logic [15:0]                r_ip_len, n_ip_len;
    logic [7:0]                 r_proto, n_proto;
    logic [15:0]                r_src, n_src;
    logic [15:0]                r_dst, n_dst;
    logic [3:0]                 r_off, n_off;
    logic [15:0]                r_udp_len, n_udp_len;

    logic                       accept;
    logic [iphp_pkg::CNT_W-1:0] pos;
    logic [7:0]                 fb;
    logic                       is_v4, is_v6;
    logic [6:0]                 base;
    logic [iphp_pkg::CNT_W-1:0] rel;
    logic                       in_l4;

    assign accept = i_push && !i_q_full;
    assign pos    = r_count;
    assign fb     = (pos == '0) ? i_data_byte : r_first;
    assign is_v4  = (fb[7:4] == iphp_pkg::VER_V4);
    assign is_v6  = (fb[7:4] == iphp_pkg::VER_V6);
    // l4 header starts at ihl*4 for ipv4, fixed 40 for ipv6
    assign base   = is_v4 ? {1'b0, fb[3:0], 2'b00} : 7'(iphp_pkg::V6_HDR);
    assign rel    = pos - {{(iphp_pkg::CNT_W-7){1'b0}}, base};
    assign in_l4  = (pos >= {{(iphp_pkg::CNT_W-7){1'b0}}, base});

    always_comb begin
        n_count   = (r_count == iphp_pkg::CNT_MAX) ? r_count
                                                   : r_count + 1'b1;
        n_first   = r_first;
        n_ip_len  = r_ip_len;
        n_proto   = r_proto;
        n_src     = r_src;
        n_dst     = r_dst;
        n_off     = r_off;
        n_udp_len = r_udp_len;

        if (pos == '0) begin
            n_first = i_data_byte;
        end

        // fixed ip header fields
        if (is_v4) begin
            if (pos == iphp_pkg::CNT_W'(2)) n_ip_len[15:8] = i_data_byte;
            if (pos == iphp_pkg::CNT_W'(3)) n_ip_len[7:0]  = i_data_byte;
            if (pos == iphp_pkg::CNT_W'(9)) n_proto        = i_data_byte;
        end else if (is_v6) begin
            if (pos == iphp_pkg::CNT_W'(4)) n_ip_len[15:8] = i_data_byte;
            if (pos == iphp_pkg::CNT_W'(5)) n_ip_len[7:0]  = i_data_byte;
            if (pos == iphp_pkg::CNT_W'(6)) n_proto        = i_data_byte;
        end

        // l4 fields, taken whatever the protocol
        if ((is_v4 || is_v6) && in_l4) begin
            unique case (rel)
                iphp_pkg::CNT_W'(0):  n_src[15:8]     = i_data_byte;
                iphp_pkg::CNT_W'(1):  n_src[7:0]      = i_data_byte;
                iphp_pkg::CNT_W'(2):  n_dst[15:8]     = i_data_byte;
                iphp_pkg::CNT_W'(3):  n_dst[7:0]      = i_data_byte;
                iphp_pkg::CNT_W'(4):  n_udp_len[15:8] = i_data_byte;
                iphp_pkg::CNT_W'(5):  n_udp_len[7:0]  = i_data_byte;
                iphp_pkg::CNT_W'(12): n_off           = i_data_byte[7:4];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_job_wr         = accept && i_end_of_packet;
        o_job.first_byte = n_first;
        o_job.len        = n_count;
        o_job.ip_len     = n_ip_len;
        o_job.proto      = n_proto;
        o_job.sport      = n_src;
        o_job.dport      = n_dst;
        o_job.tcp_off    = n_off;
        o_job.udp_len    = n_udp_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_first   <= '0;
            r_ip_len  <= '0;
            r_proto   <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_off     <= '0;
            r_udp_len <= '0;
        end else if (accept) begin
            if (i_end_of_packet) begin
                // packet done, start clean for the next one
                r_count   <= '0;
                r_first   <= '0;
                r_ip_len  <= '0;
                r_proto   <= '0;
                r_src     <= '0;
                r_dst     <= '0;
                r_off     <= '0;
                r_udp_len <= '0;
            end else begin
                r_count   <= n_count;
                r_first   <= n_first;
                r_ip_len  <= n_ip_len;
                r_proto   <= n_proto;
                r_src     <= n_src;
                r_dst     <= n_dst;
                r_off     <= n_off;
                r_udp_len <= n_udp_len;
            end
        end
    end

endmodule

`default_nettype wire

### design/iphp_jobq.sv
// iphp_jobq: short fifo of captured packets between front end and checker
// depends on iphp_pkg for the t_job record
`timescale 1ns / 1ps
`default_nettype none

module iphp_jobq #(
    parameter int unsigned DEPTH = iphp_pkg::JOBQ_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr,
    input  wire iphp_pkg::t_job i_job,
    input  wire                 i_rd,
    output logic                o_full,
    output logic                o_valid,
    output iphp_pkg::t_job      o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    iphp_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    // the front end must never write a packet into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("job queue written while full");
`endif

endmodule

`default_nettype wire

### design/iphp_back.sv
// iphp_back: two-stage header check (ip, then tcp/udp) and result register
// depends on iphp_pkg; takes t_job records from the job queue
`timescale 1ns / 1ps
`default_nettype none

module iphp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    input  wire iphp_pkg::t_job i_job,
    output logic                o_job_rd,
    input  wire                 i_pop,
    output logic                o_empty,
    output logic                o_status,
    output logic [2:0]          o_ip_version,
    output logic [7:0]          o_protocol,
    output logic [5:0]          o_ip_header_length,
    output logic [5:0]          o_l4_header_length,
    output logic [6:0]          o_header_length,
    output logic [15:0]         o_payload_length,
    output logic [15:0]         o_src_port,
    output logic [15:0]         o_dst_port
);

    typedef struct packed {
        logic        ok;
        logic [2:0]  ver;
        logic [5:0]  ip_h;
        logic [15:0] avail;
        logic [7:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [3:0]  tcp_off;
        logic [15:0] udp_len;
    } t_s1;

    typedef struct packed {
        logic        status;
        logic [2:0]  ver;
        logic [7:0]  proto;
        logic [5:0]  ip_h;
        logic [5:0]  l4_h;
        logic [6:0]  hdr;
        logic [15:0] pay;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_res;

    localparam int unsigned LW = iphp_pkg::CNT_W;

    logic r_s1_valid, r_out_valid;
    t_s1  r_s1, n_s1;
    t_res r_out, n_out;
    logic out_free, s1_free;

    // ip stage signals
    logic [3:0]    ver_nib;
    logic [5:0]    ip_h4;
    logic [LW-1:0] len;
    logic [LW-1:0] ip_len_x;
    logic          v4_ok, v6_ok;

    // l4 stage signals
    logic [5:0]    tcp_h;
    logic          tcp_ok, udp_ok;

    assign out_free = !r_out_valid || i_pop;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_job_rd = i_job_valid && s1_free;

    // stage 1: ip header checks and bytes left for l4
    always_comb begin
        ver_nib  = i_job.first_byte[7:4];
        ip_h4    = {i_job.first_byte[3:0], 2'b00};
        len      = i_job.len;
        ip_len_x = {{(LW-16){1'b0}}, i_job.ip_len};

        v4_ok = (ver_nib == iphp_pkg::VER_V4)
             && (len >= LW'(iphp_pkg::V4_MIN_HDR))
             && (ip_h4 >= 6'(iphp_pkg::V4_MIN_HDR))
             && ({{(LW-6){1'b0}}, ip_h4} <= len)
             && (i_job.ip_len >= {10'b0, ip_h4})
             && (ip_len_x <= len);
        v6_ok = (ver_nib == iphp_pkg::VER_V6)
             && (len >= LW'(iphp_pkg::V6_HDR))
             && (LW'(iphp_pkg::V6_HDR) + ip_len_x <= len);

        n_s1.ok      = v4_ok || v6_ok;
        n_s1.ver     = ver_nib[2:0];
        n_s1.ip_h    = v6_ok ? 6'(iphp_pkg::V6_HDR) : ip_h4;
        n_s1.avail   = v6_ok ? i_job.ip_len : i_job.ip_len - {10'b0, ip_h4};
        n_s1.proto   = i_job.proto;
        n_s1.sport   = i_job.sport;
        n_s1.dport   = i_job.dport;
        n_s1.tcp_off = i_job.tcp_off;
        n_s1.udp_len = i_job.udp_len;
    end

    // stage 2: tcp or udp checks, payload length, zero fields on error
    always_comb begin
        tcp_h  = {r_s1.tcp_off, 2'b00};
        tcp_ok = (r_s1.proto == iphp_pkg::PROTO_TCP)
              && (r_s1.avail >= 16'(iphp_pkg::TCP_MIN_HDR))
              && (tcp_h >= 6'(iphp_pkg::TCP_MIN_HDR))
              && ({10'b0, tcp_h} <= r_s1.avail);
        udp_ok = (r_s1.proto == iphp_pkg::PROTO_UDP)
              && (r_s1.avail >= 16'(iphp_pkg::UDP_HDR))
              && (r_s1.udp_len >= 16'(iphp_pkg::UDP_HDR))
              && (r_s1.udp_len <= r_s1.avail);

        n_out = '0;
        n_out.status = 1'b1;
        if (r_s1.ok && (tcp_ok || udp_ok)) begin
            n_out.status = 1'b0;
            n_out.ver    = r_s1.ver;
            n_out.proto  = r_s1.proto;
            n_out.ip_h   = r_s1.ip_h;
            n_out.l4_h   = tcp_ok ? tcp_h : 6'(iphp_pkg::UDP_HDR);
            n_out.hdr    = {1'b0, r_s1.ip_h} + {1'b0, n_out.l4_h};
            n_out.pay    = tcp_ok ? r_s1.avail - {10'b0, tcp_h}
                                  : r_s1.udp_len - 16'(iphp_pkg::UDP_HDR);
            n_out.sport  = r_s1.sport;
            n_out.dport  = r_s1.dport;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_job_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_rd) begin
            r_s1 <= n_s1;
        end
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_status           = r_out.status;
    assign o_ip_version       = r_out.ver;
    assign o_protocol         = r_out.proto;
    assign o_ip_header_length = r_out.ip_h;
    assign o_l4_header_length = r_out.l4_h;
    assign o_header_length    = r_out.hdr;
    assign o_payload_length   = r_out.pay;
    assign o_src_port         = r_out.sport;
    assign o_dst_port         = r_out.dport;

`ifndef SYNTH
    // an error result carries nothing but the status bit
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status) |-> (o_ip_version == 3'd0 && o_protocol == 8'd0
            && o_header_length == 7'd0 && o_payload_length == 16'd0
            && o_src_port == 16'd0 && o_dst_port == 16'd0))
        else $error("error result with non-zero fields");

    // a good result is ipv4 or ipv6 and its header length adds up
    a_ok_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_status) |-> ((o_ip_version == 3'd4 || o_ip_version == 3'd6)
            && o_header_length == {1'b0, o_ip_header_length} + {1'b0, o_l4_header_length}))
        else $error("good result with inconsistent header lengths");

    // a good udp result always has the fixed 8 byte l4 header
    a_udp_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_status && o_protocol == iphp_pkg::PROTO_UDP)
            |-> (o_l4_header_length == 6'(iphp_pkg::UDP_HDR)))
        else $error("udp result with wrong l4 header length");

    // a held check result must not be lost when the output stays full
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> r_s1_valid)
        else $error("check stage dropped a packet under back pressure");
`endif

endmodule

`default_nettype wire

### sim/ip_tcp_udp_header_parser_checker.sv
// ip_tcp_udp_header_parser_checker: predicts the parse result of every packet and checks it
// watches the byte and result request channels of the parser; depends on iphp_pkg
`timescale 1ns / 1ps

module ip_tcp_udp_header_parser_checker
    import iphp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire         i_full,
    input  wire [7:0]   i_data_byte,
    input  wire         i_end_of_packet,
    input  wire         i_empty,
    input  wire         i_pop,
    input  wire         i_status,
    input  wire [2:0]   i_ip_version,
    input  wire [7:0]   i_protocol,
    input  wire [5:0]   i_ip_header_length,
    input  wire [5:0]   i_l4_header_length,
    input  wire [6:0]   i_header_length,
    input  wire [15:0]  i_payload_length,
    input  wire [15:0]  i_src_port,
    input  wire [15:0]  i_dst_port,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ERR  = 1'b1;
    localparam int   MAX_REPORTS = 10;

    typedef struct packed {
        logic        status;
        logic [2:0]  ip_version;
        logic [7:0]  protocol;
        logic [5:0]  ip_hdr_len;
        logic [5:0]  l4_hdr_len;
        logic [6:0]  hdr_len;
        logic [15:0] pay_bytes;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_parse_result;

    t_parse_result awaited_results[$];
    int            failures = 0;

    // header fields gathered from the packet in flight
    logic [CNT_W-1:0] seen_bytes;
    logic [7:0]       ver_ihl;
    logic [15:0]      ip_len_field;
    logic [7:0]       l4_proto;
    logic [15:0]      src_cap;
    logic [15:0]      dst_cap;
    logic [15:0]      udp_len_cap;
    logic [3:0]       tcp_off_cap;

    task automatic clear_capture();
        seen_bytes   = '0;
        ver_ihl      = '0;
        ip_len_field = '0;
        l4_proto     = '0;
        src_cap      = '0;
        dst_cap      = '0;
        udp_len_cap  = '0;
        tcp_off_cap  = '0;
    endtask

    task automatic capture_header_byte(input int unsigned pos, input logic [7:0] b);
        logic [7:0]  fb;
        int unsigned base;
        fb = (pos == 0) ? b : ver_ihl;
        if (pos == 0) ver_ihl = b;
        if (fb[7:4] == VER_V4) begin
            if (pos == 2) ip_len_field[15:8] = b;
            if (pos == 3) ip_len_field[7:0] = b;
            if (pos == 9) l4_proto = b;
            base = fb[3:0] * 4;
        end else if (fb[7:4] == VER_V6) begin
            if (pos == 4) ip_len_field[15:8] = b;
            if (pos == 5) ip_len_field[7:0] = b;
            if (pos == 6) l4_proto = b;
            base = V6_HDR;
        end else begin
            return;
        end
        // l4 fields are taken whatever the protocol turns out to be
        if (pos == base)      src_cap[15:8]     = b;
        if (pos == base + 1)  src_cap[7:0]      = b;
        if (pos == base + 2)  dst_cap[15:8]     = b;
        if (pos == base + 3)  dst_cap[7:0]      = b;
        if (pos == base + 4)  udp_len_cap[15:8] = b;
        if (pos == base + 5)  udp_len_cap[7:0]  = b;
        if (pos == base + 12) tcp_off_cap       = b[7:4];
    endtask

    function automatic t_parse_result judge_packet(input int unsigned len);
        t_parse_result bad;
        t_parse_result good;
        int unsigned   ip_h;
        int unsigned   avail;
        int unsigned   l4_h;
        int unsigned   pay;
        bad        = '0;
        bad.status = STATUS_ERR;
        if (ver_ihl[7:4] == VER_V4) begin
            ip_h = ver_ihl[3:0] * 4;
            if (len < V4_MIN_HDR || ip_h < V4_MIN_HDR || ip_h > len) return bad;
            if (ip_len_field < ip_h || ip_len_field > len) return bad;
            avail = ip_len_field - ip_h;
        end else if (ver_ihl[7:4] == VER_V6) begin
            if (len < V6_HDR || V6_HDR + ip_len_field > len) return bad;
            ip_h  = V6_HDR;
            avail = ip_len_field;
        end else begin
            return bad;
        end
        if (l4_proto == PROTO_TCP) begin
            l4_h = tcp_off_cap * 4;
            if (avail < TCP_MIN_HDR || l4_h < TCP_MIN_HDR || l4_h > avail) return bad;
            pay = avail - l4_h;
        end else if (l4_proto == PROTO_UDP) begin
            if (avail < UDP_HDR || udp_len_cap < UDP_HDR || udp_len_cap > avail) return bad;
            l4_h = UDP_HDR;
            pay  = udp_len_cap - UDP_HDR;
        end else begin
            return bad;
        end
        good.status     = STATUS_OK;
        good.ip_version = 3'(ver_ihl[7:4]);
        good.protocol   = l4_proto;
        good.ip_hdr_len = 6'(ip_h);
        good.l4_hdr_len = 6'(l4_h);
        good.hdr_len    = 7'(ip_h + l4_h);
        good.pay_bytes  = 16'(pay);
        good.sport      = src_cap;
        good.dport      = dst_cap;
        return good;
    endfunction

    task automatic report_mismatch(input string what, input t_parse_result want,
                                   input t_parse_result got);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%0t: %s", $time, what);
            $display("  exp st %0d ver %0d pr %0d iph %0d l4h %0d hdr %0d pay %0d sp %0d dp %0d",
                     want.status, want.ip_version, want.protocol, want.ip_hdr_len,
                     want.l4_hdr_len, want.hdr_len, want.pay_bytes, want.sport,
                     want.dport);
            $display("  act st %0d ver %0d pr %0d iph %0d l4h %0d hdr %0d pay %0d sp %0d dp %0d",
                     got.status, got.ip_version, got.protocol, got.ip_hdr_len,
                     got.l4_hdr_len, got.hdr_len, got.pay_bytes, got.sport,
                     got.dport);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_parse_result got;
        t_parse_result want;
        if (!i_rst_n) begin
            clear_capture();
            awaited_results.delete();
        end else begin
            if (i_pop && !i_empty) begin
                got = {i_status, i_ip_version, i_protocol, i_ip_header_length,
                       i_l4_header_length, i_header_length, i_payload_length,
                       i_src_port, i_dst_port};
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no packet awaiting one", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) report_mismatch("result mismatch", want, got);
                end
            end
            if (i_push && !i_full) begin
                capture_header_byte(seen_bytes, i_data_byte);
                if (seen_bytes != CNT_MAX) seen_bytes = seen_bytes + 1'b1;
                if (i_end_of_packet) begin
                    awaited_results.push_back(judge_packet(seen_bytes));
                    clear_capture();
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= failures;
    end

endmodule

### sim/tb_ip_tcp_udp_header_parser.sv
// tb_ip_tcp_udp_header_parser: stimulus and verdict for the ip/tcp/udp header parser
// depends on iphp_pkg, ip_tcp_udp_header_parser and ip_tcp_udp_header_parser_checker
`timescale 1ns / 1ps

module tb_ip_tcp_udp_header_parser;

    import iphp_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 3;
    // bytes of random packets per idling phase
    localparam int PHASE_BYTES  = 60;
    localparam int PHASE_PKTS   = 2;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 8;
    // watchdog limit on the whole run
    localparam int unsigned CYCLE_LIMIT = 2000000;

    localparam logic [3:0] VER_BAD    = 4'd15;
    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // ways a random packet gets broken
    typedef enum int {
        FLAW_IP_LEN_LONG,
        FLAW_IP_LEN_SHORT,
        FLAW_UDP_LEN,
        FLAW_IHL,
        FLAW_TCP_OFF,
        FLAW_PROTO,
        FLAW_VERSION,
        FLAW_TRUNCATE
    } t_flaw;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        push            = 1'b0;
    logic [7:0]  i_data_byte     = '0;
    logic        i_end_of_packet = 1'b0;
    logic        pop             = 1'b0;
    wire         full;
    wire         empty;
    wire         o_status;
    wire [2:0]   o_ip_version;
    wire [7:0]   o_protocol;
    wire [5:0]   o_ip_header_length;
    wire [5:0]   o_l4_header_length;
    wire [6:0]   o_header_length;
    wire [15:0]  o_payload_length;
    wire [15:0]  o_src_port;
    wire [15:0]  o_dst_port;

    int          fail_count;
    int          results_pending;

    // idling, in percent: chance of an idle cycle before a byte, chance of a stalled pop
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    int unsigned cycle_count  = 0;
    int unsigned bytes_sent   = 0;
    int unsigned packets_sent = 0;

    // bytes of the packet being sent
    logic [7:0]  pkt[$];

    ip_tcp_udp_header_parser u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_data_byte        (i_data_byte),
        .i_end_of_packet    (i_end_of_packet),
        .empty              (empty),
        .pop                (pop),
        .o_status           (o_status),
        .o_ip_version       (o_ip_version),
        .o_protocol         (o_protocol),
        .o_ip_header_length (o_ip_header_length),
        .o_l4_header_length (o_l4_header_length),
        .o_header_length    (o_header_length),
        .o_payload_length   (o_payload_length),
        .o_src_port         (o_src_port),
        .o_dst_port         (o_dst_port)
    );

    ip_tcp_udp_header_parser_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_data_byte        (i_data_byte),
        .i_end_of_packet    (i_end_of_packet),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_status           (o_status),
        .i_ip_version       (o_ip_version),
        .i_protocol         (o_protocol),
        .i_ip_header_length (o_ip_header_length),
        .i_l4_header_length (o_l4_header_length),
        .i_header_length    (o_header_length),
        .i_payload_length   (o_payload_length),
        .i_src_port         (o_src_port),
        .i_dst_port         (o_dst_port),
        .o_fail_count       (fail_count),
        .o_pending          (results_pending)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // result side: pop is redrawn every cycle, stalling at the phase's rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[ip_tcp_udp_header_parser] ERROR");
            $finish;
        end
    end

    task automatic put_word(input int idx, input logic [15:0] w);
        pkt[idx]     = w[15:8];
        pkt[idx + 1] = w[7:0];
    endtask

    // lays out an ip packet with a tcp or udp header; the deltas push the length
    // fields off their consistent values, tail adds bytes past the ip length
    task automatic build_ip_packet(input bit is_v6, input logic [3:0] ihl,
                                   input logic [7:0] proto, input logic [3:0] tcp_off,
                                   input int pay, input int ip_len_delta,
                                   input int udp_len_delta, input int tail);
        int iph;
        int l4h;
        int avail;
        pkt.delete();
        iph   = is_v6 ? V6_HDR : ((ihl < 5) ? V4_MIN_HDR : ihl * 4);
        l4h   = (proto == PROTO_UDP) ? UDP_HDR : ((tcp_off < 5) ? TCP_MIN_HDR : tcp_off * 4);
        avail = l4h + pay;
        repeat (iph + avail + tail) pkt.push_back(8'($urandom_range(255)));
        if (is_v6) begin
            pkt[0] = {VER_V6, 4'($urandom_range(15))};
            put_word(4, 16'(avail + ip_len_delta));
            pkt[6] = proto;
        end else begin
            pkt[0] = {VER_V4, ihl};
            put_word(2, 16'(iph + avail + ip_len_delta));
            pkt[9] = proto;
        end
        put_word(iph + 4, 16'(UDP_HDR + pay + udp_len_delta));
        // short udp packets may end before the tcp offset byte
        if (iph + 12 < pkt.size()) pkt[iph + 12] = {tcp_off, 4'($urandom_range(15))};
    endtask

    task automatic truncate_packet(input int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endtask

    // one byte request; each idle cycle before it is drawn on its own with push
    // low, otherwise push stays high from the previous byte
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gap_pct != 0) begin
            while ($urandom_range(99) < gap_pct) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
        end
        push            <= 1'b1;
        i_data_byte     <= b;
        i_end_of_packet <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // sender holds off until every predicted result has been popped
    task automatic wait_for_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    // mostly well-formed packets with random content, some broken, some noise
    task automatic make_random_packet();
        bit          is_v6;
        logic [3:0]  ihl;
        logic [3:0]  off;
        logic [3:0]  bad_ver;
        logic [7:0]  proto;
        int          pay;
        int          ip_d;
        int          udp_d;
        int          tail;
        int          pick;
        t_flaw       flaw;
        pick = $urandom_range(99);
        if (pick >= 90) begin
            // noise: random bytes, sometimes with a plausible version nibble
            pkt.delete();
            repeat ($urandom_range(1, 48)) pkt.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) pkt[0][7:4] = $urandom_range(1) ? VER_V4 : VER_V6;
            return;
        end
        is_v6 = ($urandom_range(3) == 0);
        ihl   = ($urandom_range(2) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        off   = ($urandom_range(2) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        pay   = ($urandom_range(9) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
        tail  = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
        ip_d  = 0;
        udp_d = 0;
        // a udp length below the l4 bytes is still legal
        if (proto == PROTO_UDP && $urandom_range(3) == 0) udp_d = 0 - int'($urandom_range(0, pay));
        flaw = t_flaw'($urandom_range(FLAW_TRUNCATE));
        if (pick >= 72) begin
            case (flaw)
                FLAW_IP_LEN_LONG:  ip_d = $urandom_range(1, 3);
                FLAW_IP_LEN_SHORT: ip_d = 0 - int'($urandom_range(1, 40));
                FLAW_UDP_LEN: begin
                    if ($urandom_range(1)) udp_d = $urandom_range(1, 3);
                    else udp_d = 0 - pay - int'($urandom_range(1, 8));
                end
                FLAW_IHL:          ihl   = 4'($urandom_range(0, 4));
                FLAW_TCP_OFF:      off   = 4'($urandom_range(0, 4));
                FLAW_PROTO:        proto = 8'($urandom_range(255));
                default: ;
            endcase
        end
        build_ip_packet(is_v6, ihl, proto, off, pay, ip_d, udp_d, tail);
        if (pick >= 72 && flaw == FLAW_VERSION) begin
            do bad_ver = 4'($urandom_range(15)); while (bad_ver == VER_V4 || bad_ver == VER_V6);
            pkt[0] = {bad_ver, pkt[0][3:0]};
        end
        if (pick >= 72 && flaw == FLAW_TRUNCATE) truncate_packet($urandom_range(1, pkt.size() - 1));
    endtask

    task automatic run_directed();
        // smallest well-formed udp over ipv4, no payload
        build_ip_packet(0, 5, PROTO_UDP, 0, 0, 0, 0, 0);
        send_packet();
        // largest headers: ihl 15 and data offset 15
        build_ip_packet(0, 15, PROTO_TCP, 15, 3, 0, 0, 0);
        send_packet();
        // ipv6 tcp, and ipv6 udp with bytes past the ip length
        build_ip_packet(1, 0, PROTO_TCP, 5, 4, 0, 0, 0);
        send_packet();
        build_ip_packet(1, 0, PROTO_UDP, 0, 0, 0, 0, 2);
        send_packet();
        // udp length shorter than the l4 bytes
        build_ip_packet(0, 5, PROTO_UDP, 0, 6, 0, -3, 0);
        send_packet();
        // unknown ip version
        build_ip_packet(0, 5, PROTO_UDP, 0, 2, 0, 0, 0);
        pkt[0] = {VER_BAD, pkt[0][3:0]};
        send_packet();
        // shorter than the fixed ip header, both versions
        build_ip_packet(0, 5, PROTO_TCP, 5, 0, 0, 0, 0);
        truncate_packet(V4_MIN_HDR - 1);
        send_packet();
        build_ip_packet(1, 0, PROTO_UDP, 0, 0, 0, 0, 0);
        truncate_packet(V6_HDR - 1);
        send_packet();
        // ihl below 5
        build_ip_packet(0, 4, PROTO_UDP, 0, 4, 0, 0, 0);
        send_packet();
        // ipv4 total length past the packet end, then below the header length
        build_ip_packet(0, 5, PROTO_UDP, 0, 4, 1, 0, 0);
        send_packet();
        build_ip_packet(0, 6, PROTO_UDP, 0, 4, -13, 0, 0);
        send_packet();
        // ipv6 payload length past the packet end
        build_ip_packet(1, 0, PROTO_TCP, 5, 0, 1, 0, 0);
        send_packet();
        // protocol neither tcp nor udp
        build_ip_packet(0, 5, PROTO_ICMP, 5, 4, 0, 0, 0);
        send_packet();
        // tcp data offset below 5, then beyond the l4 bytes
        build_ip_packet(0, 5, PROTO_TCP, 4, 8, 0, 0, 0);
        send_packet();
        build_ip_packet(0, 5, PROTO_TCP, 6, 0, -4, 0, 0);
        send_packet();
        // udp length below 8, then beyond the l4 bytes
        build_ip_packet(0, 5, PROTO_UDP, 0, 0, 0, -1, 0);
        send_packet();
        build_ip_packet(0, 5, PROTO_UDP, 0, 3, 0, 1, 0);
        send_packet();
        // one-byte packets at both byte extremes
        pkt.delete();
        pkt.push_back(8'h00);
        send_packet();
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet();
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall, input bit hold_off);
        int unsigned first_byte_no;
        int unsigned first_pkt_no;
        bit          held;
        gap_pct       = gap;
        stall_pct     = stall;
        first_byte_no = bytes_sent;
        first_pkt_no  = packets_sent;
        held          = 1'b0;
        while (bytes_sent - first_byte_no < PHASE_BYTES
               || packets_sent - first_pkt_no < PHASE_PKTS) begin
            if (hold_off && !held && bytes_sent - first_byte_no >= PHASE_BYTES / 2) begin
                wait_for_drain();
                held = 1'b1;
            end
            make_random_packet();
            send_packet();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases at full rate on both sides
        run_directed();

        // random packets under each idling pattern
        run_phase(0, 0, 1'b0);
        run_phase(65, 0, 1'b1);
        run_phase(0, 65, 1'b0);
        run_phase(28, 28, 1'b0);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_pending == 0) begin
            $display("[ip_tcp_udp_header_parser] OK");
        end else begin
            $display("[ip_tcp_udp_header_parser] ERROR");
        end
        $finish;
    end

endmodule
